[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL of the surface evaluator.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define BZ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define BZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bezsurf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bezsurf_pkg;

  // Grid storage and derived widths.
  localparam int MAX_GRID = 5;
  localparam int MIN_GRID = 3;
  localparam int COORD_W  = 16;
  localparam int PARAM_W  = 16;
  localparam int CFG_W    = 3;
  localparam int IDX_W    = 3;
  localparam int FRAC_W   = 15;
  localparam int PT_W     = 3 * COORD_W;
  localparam int GA_W     = $clog2(MAX_GRID * MAX_GRID);
  localparam int WA_W     = $clog2(2 * MAX_GRID);
  localparam int GRID_DEPTH = MAX_GRID * MAX_GRID;
  localparam int WORK_DEPTH = 2 * MAX_GRID;
  localparam int DRAIN_CYC  = 3;

  localparam logic [PARAM_W-1:0] ONE_Q15 = PARAM_W'(1 << FRAC_W);

  // Request command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } bezsurf_state_t;

  // Tag that travels alongside each element read from memory.
  typedef struct packed {
    logic            vld;
    logic            lerp;
    logic            grid_src;
    logic            fin;
    logic [WA_W-1:0] waddr;
  } bezsurf_tag_t;

  // Control from the sequencer to the datapath and memories.
  typedef struct packed {
    logic [GA_W-1:0] grid_raddr;
    logic [WA_W-1:0] work_raddr;
    bezsurf_tag_t    tag1;
    bezsurf_tag_t    tag3;
    logic            use_v;
  } bezsurf_ctl_t;

  // Index of the last point in a row for a given grid size setting.
  function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] size);
    logic [IDX_W-1:0] res;
    if (32'(size) < 32'(MIN_GRID)) begin
      res = IDX_W'(MIN_GRID - 1);
    end else if (32'(size) > 32'(MAX_GRID)) begin
      res = IDX_W'(MAX_GRID - 1);
    end else begin
      res = IDX_W'(size - CFG_W'(1));
    end
    return res;
  endfunction

  // Parameters above one are held at one.
  function automatic logic [PARAM_W-1:0] clamp_param(input logic [PARAM_W-1:0] p);
    return (p > ONE_Q15) ? ONE_Q15 : p;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bezsurf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bezsurf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 25
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/bezsurf_lerp.sv]
`timescale 1ns / 1ps
`default_nettype none

module bezsurf_lerp
  import bezsurf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire coord_t             din,
  input  wire logic [PARAM_W-1:0] t,
  output coord_t                  res
);

  coord_t                        prev_r;
  coord_t                        a1_r;
  logic signed [COORD_W:0]       d1_r;
  coord_t                        a2_r;
  logic [COORD_W-1:0]            p2_r;
  logic signed [COORD_W+PARAM_W+1:0] prod;

  // Keep the previous element so that neighbours can be combined.
  always_ff @(posedge clk) begin
    if (en) begin
      prev_r <= din;
    end
  end

  // Stage one: difference of the neighbouring points.
  always_ff @(posedge clk) begin
    a1_r <= prev_r;
    d1_r <= $signed({din[COORD_W-1], din}) - $signed({prev_r[COORD_W-1], prev_r});
  end

  // Stage two: scale by the parameter; the floor shift is a bit select.
  assign prod = $signed({1'b0, t}) * d1_r;

  always_ff @(posedge clk) begin
    a2_r <= a1_r;
    p2_r <= prod[FRAC_W+COORD_W-1:FRAC_W];
  end

  // Stage three: the result always lies between its two end points.
  assign res = a2_r + $signed(p2_r);

endmodule

`default_nettype wire

[hw/rtl/bezsurf_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bezsurf_seq
  import bezsurf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start_eval,
  input  wire logic [IDX_W-1:0] last_idx,
  output logic                  busy,
  output bezsurf_ctl_t          ctl
);

  bezsurf_state_t   state_r, state_nxt;
  logic [IDX_W-1:0] nm1_r, nm1_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] lvl_r, lvl_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [1:0]       drain_r, drain_nxt;
  logic             phase_v_r, phase_v_nxt;
  bezsurf_tag_t     tag0, tag1_r, tag2_r, tag3_r;

  logic level_end;
  logic drain_end;
  logic first_lvl;
  logic last_lvl;

  assign level_end = (j_r == lvl_r);
  assign drain_end = (drain_r == 2'(DRAIN_CYC - 1));
  assign first_lvl = (lvl_r == nm1_r);
  assign last_lvl  = (lvl_r == IDX_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_eval) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (level_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_end) begin
          state_nxt = (last_lvl && phase_v_r) ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Row, level and element counters.
  always_comb begin
    nm1_nxt     = nm1_r;
    row_nxt     = row_r;
    lvl_nxt     = lvl_r;
    j_nxt       = j_r;
    drain_nxt   = drain_r;
    phase_v_nxt = phase_v_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_eval) begin
          nm1_nxt     = last_idx;
          row_nxt     = '0;
          lvl_nxt     = last_idx;
          j_nxt       = '0;
          drain_nxt   = '0;
          phase_v_nxt = 1'b0;
        end
      end
      ST_READ: begin
        if (level_end) begin
          j_nxt     = '0;
          drain_nxt = '0;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_end) begin
          drain_nxt = '0;
          if (!last_lvl) begin
            lvl_nxt = lvl_r - IDX_W'(1);
          end else if (!phase_v_r) begin
            lvl_nxt = nm1_r;
            if (row_r == nm1_r) begin
              phase_v_nxt = 1'b1;
            end else begin
              row_nxt = row_r + IDX_W'(1);
            end
          end
        end else begin
          drain_nxt = drain_r + 2'd1;
        end
      end
      default: begin
        drain_nxt = '0;
      end
    endcase
  end

  // Read addresses and the tag of the element being read.
  always_comb begin
    tag0          = '0;
    tag0.vld      = (state_r == ST_READ);
    tag0.lerp     = (j_r != '0);
    tag0.grid_src = !phase_v_r && first_lvl;
    tag0.fin      = phase_v_r && last_lvl;
    if (last_lvl && !phase_v_r) begin
      tag0.waddr = WA_W'(MAX_GRID) + WA_W'(row_r);
    end else begin
      tag0.waddr = WA_W'(j_r - IDX_W'(1));
    end

    ctl.grid_raddr = GA_W'(row_r) * GA_W'(MAX_GRID) + GA_W'(j_r);
    if (phase_v_r && first_lvl) begin
      ctl.work_raddr = WA_W'(MAX_GRID) + WA_W'(j_r);
    end else begin
      ctl.work_raddr = WA_W'(j_r);
    end
    ctl.tag1  = tag1_r;
    ctl.tag3  = tag3_r;
    ctl.use_v = phase_v_r;
    busy      = (state_r != ST_IDLE);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      nm1_r     <= IDX_W'(MIN_GRID - 1);
      row_r     <= '0;
      lvl_r     <= IDX_W'(1);
      j_r       <= '0;
      drain_r   <= '0;
      phase_v_r <= 1'b0;
      tag1_r    <= '0;
      tag2_r    <= '0;
      tag3_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      nm1_r     <= nm1_nxt;
      row_r     <= row_nxt;
      lvl_r     <= lvl_nxt;
      j_r       <= j_nxt;
      drain_r   <= drain_nxt;
      phase_v_r <= phase_v_nxt;
      tag1_r    <= tag0;
      tag2_r    <= tag1_r;
      tag3_r    <= tag2_r;
    end
  end

  // The final surface point is written in the last drain cycle of the v pass.
  `BZ_ASSERT_SAME(a_fin_in_drain, tag3_r.vld && tag3_r.lerp && tag3_r.fin,
    state_r == ST_DRAIN && phase_v_r && drain_end, "final result outside last drain cycle")
  // The reduction level always stays within the grid in use.
  `BZ_ASSERT_SAME(a_lvl_range, state_r != ST_IDLE,
    lvl_r >= IDX_W'(1) && lvl_r <= nm1_r && j_r <= lvl_r, "level counter out of range")
  // Reads of a level never start while results of the previous level are in flight.
  `BZ_ASSERT_SAME(a_no_overlap, state_r == ST_READ && j_r == '0,
    !tag1_r.vld && !tag2_r.vld && !tag3_r.vld, "level started before pipeline drained")

endmodule

`default_nettype wire

[hw/rtl/bezier_surface_point_eval.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Bezier surface evaluator. A request with in_command = write stores one control
// point in the grid memory at the accepting edge, unless row or column lies outside
// the storage, and never raises busy. An evaluate request raises busy and the point
// appears on out_surface_* with a one-cycle out_valid strobe in the first cycle with
// busy low again; the receiver must take it then.
// An evaluation walks the reduction levels row by row and then once along v: each
// level streams its points through a single read port, of the grid memory for the
// first u level and of the working memory otherwise, and then waits for the
// subtract, multiply and add stages to write back before the next level reads.

module bezier_surface_point_eval
  import bezsurf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_command,
  input  wire logic [2:0]         in_row,
  input  wire logic [2:0]         in_col,
  input  wire coord_t             in_point_x,
  input  wire coord_t             in_point_y,
  input  wire coord_t             in_point_z,
  input  wire logic [PARAM_W-1:0] in_param_u,
  input  wire logic [PARAM_W-1:0] in_param_v,
  input  wire logic               cfg_wr_en,
  input  wire logic [CFG_W-1:0]   cfg_wr_data,
  output logic                    out_valid,
  output coord_t                  out_surface_x,
  output coord_t                  out_surface_y,
  output coord_t                  out_surface_z
);

  logic [CFG_W-1:0]   grid_size_r;
  logic [PARAM_W-1:0] u_r, v_r;
  logic               accept;
  logic               start_eval;
  logic               grid_we;
  logic [GA_W-1:0]    grid_waddr;
  point_t             grid_wdata;
  logic [PT_W-1:0]    grid_rdata;
  logic [PT_W-1:0]    work_rdata;
  point_t             rd_pt;
  point_t             res_pt;
  logic               work_we;
  logic [PARAM_W-1:0] t_sel;
  logic               out_valid_r;
  point_t             out_pt_r;
  bezsurf_ctl_t       ctl;

  assign accept     = start && !busy;
  assign start_eval = accept && (in_command == CMD_EVAL);

  // Grid size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= CFG_W'(MIN_GRID);
    end else if (cfg_wr_en) begin
      grid_size_r <= cfg_wr_data;
    end
  end

  // Parameters are captured with the evaluate request.
  always_ff @(posedge clk) begin
    if (start_eval) begin
      u_r <= clamp_param(in_param_u);
      v_r <= clamp_param(in_param_v);
    end
  end

  // Control point writes outside the storage are dropped.
  assign grid_we = accept && (in_command == CMD_WRITE)
                 && (32'(in_row) < 32'(MAX_GRID)) && (32'(in_col) < 32'(MAX_GRID));
  assign grid_waddr = GA_W'(in_row) * GA_W'(MAX_GRID) + GA_W'(in_col);
  assign grid_wdata = '{x: in_point_x, y: in_point_y, z: in_point_z};

  bezsurf_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_eval (start_eval),
    .last_idx   (last_index(grid_size_r)),
    .busy       (busy),
    .ctl        (ctl)
  );

  bezsurf_ram #(
    .WIDTH (PT_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (ctl.grid_raddr),
    .rdata (grid_rdata)
  );

  // Working memory: row scratch in the lower half, row results in the upper half.
  assign work_we = ctl.tag3.vld && ctl.tag3.lerp;

  bezsurf_ram #(
    .WIDTH (PT_W),
    .DEPTH (WORK_DEPTH)
  ) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (ctl.tag3.waddr),
    .wdata (res_pt),
    .raddr (ctl.work_raddr),
    .rdata (work_rdata)
  );

  // One lerp pipeline per coordinate.
  assign rd_pt = ctl.tag1.grid_src ? point_t'(grid_rdata) : point_t'(work_rdata);
  assign t_sel = ctl.use_v ? v_r : u_r;

  bezsurf_lerp u_lerp_x (
    .clk (clk),
    .en  (ctl.tag1.vld),
    .din (rd_pt.x),
    .t   (t_sel),
    .res (res_pt.x)
  );

  bezsurf_lerp u_lerp_y (
    .clk (clk),
    .en  (ctl.tag1.vld),
    .din (rd_pt.y),
    .t   (t_sel),
    .res (res_pt.y)
  );

  bezsurf_lerp u_lerp_z (
    .clk (clk),
    .en  (ctl.tag1.vld),
    .din (rd_pt.z),
    .t   (t_sel),
    .res (res_pt.z)
  );

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= work_we && ctl.tag3.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (work_we && ctl.tag3.fin) begin
      out_pt_r <= res_pt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_surface_x = out_pt_r.x;
  assign out_surface_y = out_pt_r.y;
  assign out_surface_z = out_pt_r.z;

  // The result strobe is high in the first cycle in which busy is low again after an evaluation.
  `BZ_ASSERT_SAME(a_out_after_busy, out_valid_r, !busy && $past(busy),
    "result strobe not aligned with end of evaluation")

endmodule

`default_nettype wire
